// File: sv/mcmp_pkg.sv
// ----------------------------------------------------------------------------
// mcmp_pkg
// Shared types, codes and micro-program ROM of the monitor poller.
// ----------------------------------------------------------------------------
package mcmp_pkg;

   // field widths fixed by the interface
   localparam int REQ_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 2;
   localparam int CH_W     = 3;
   localparam int REG_W    = 6;
   localparam int LEN_W    = 2;
   localparam int BUS_W    = 2;
   localparam int STAT_W   = 2;
   localparam int VBUS_W   = 20;
   localparam int CURR_W   = 20;
   localparam int TEMP_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W   = 2;
   localparam int UPC_W    = 4;

   // request codes
   localparam logic [REQ_W-1:0] REQ_START   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_RD_DONE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RD_FAIL = 3'd2;
   localparam logic [REQ_W-1:0] REQ_TICK    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_COLLECT = 3'd4;

   // command kinds
   localparam logic [KIND_W-1:0] CMD_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] CMD_READ  = 2'd1;
   localparam logic [KIND_W-1:0] CMD_ABORT = 2'd2;

   // reported bus state
   localparam logic [BUS_W-1:0] BUS_IDLE = 2'd0;
   localparam logic [BUS_W-1:0] BUS_BUSY = 2'd1;
   localparam logic [BUS_W-1:0] BUS_DONE = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_ADC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 1'd1;

   localparam logic [CSR_W-1:0] TIMEOUT_RESET = 16'd10;

   // sequence steps
   localparam logic [STEP_W-1:0] STEP_ADC  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_VBUS = 2'd1;
   localparam logic [STEP_W-1:0] STEP_CURR = 2'd2;
   localparam logic [STEP_W-1:0] STEP_TEMP = 2'd3;

   typedef enum logic [2:0] {
      POLL_IDLE = 3'b001,
      POLL_BUSY = 3'b010,
      POLL_DONE = 3'b100
   } poll_state_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_START,
      UOP_STORE,
      UOP_SKIP,
      UOP_ISSUE,
      UOP_TICK,
      UOP_REFUSE,
      UOP_IGNORE,
      UOP_CINIT,
      UOP_CEMIT
   } uop_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_BUSY,
      COND_NOT_BUSY,
      COND_NOT_DONE,
      COND_MORE
   } cond_type;

   typedef struct packed {
      uop_type           uop;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
      logic              last;
   } ucw_type;

   // micro-program addresses
   localparam logic [UPC_W-1:0] UA_START  = 4'd0;
   localparam logic [UPC_W-1:0] UA_ISSUE  = 4'd2;
   localparam logic [UPC_W-1:0] UA_REFUSE = 4'd3;
   localparam logic [UPC_W-1:0] UA_IGNORE = 4'd4;
   localparam logic [UPC_W-1:0] UA_RD     = 4'd5;
   localparam logic [UPC_W-1:0] UA_FAIL   = 4'd7;
   localparam logic [UPC_W-1:0] UA_TICK   = 4'd9;
   localparam logic [UPC_W-1:0] UA_COL    = 4'd11;
   localparam logic [UPC_W-1:0] UA_CEMIT  = 4'd13;

   function automatic ucw_type ucode_rom(input logic [UPC_W-1:0] pc);
      ucw_type w;
      w = '{uop: UOP_IGNORE, cond: COND_NONE, target: UA_IGNORE, last: 1'b1};
      case (pc)
         4'd0:  w = '{UOP_NOP,    COND_BUSY,     UA_REFUSE, 1'b0};
         4'd1:  w = '{UOP_START,  COND_NONE,     UA_START,  1'b0};
         4'd2:  w = '{UOP_ISSUE,  COND_NONE,     UA_START,  1'b1};
         4'd3:  w = '{UOP_REFUSE, COND_NONE,     UA_START,  1'b1};
         4'd4:  w = '{UOP_IGNORE, COND_NONE,     UA_START,  1'b1};
         4'd5:  w = '{UOP_NOP,    COND_NOT_BUSY, UA_IGNORE, 1'b0};
         4'd6:  w = '{UOP_STORE,  COND_ALWAYS,   UA_ISSUE,  1'b0};
         4'd7:  w = '{UOP_NOP,    COND_NOT_BUSY, UA_IGNORE, 1'b0};
         4'd8:  w = '{UOP_SKIP,   COND_ALWAYS,   UA_ISSUE,  1'b0};
         4'd9:  w = '{UOP_NOP,    COND_NOT_BUSY, UA_IGNORE, 1'b0};
         4'd10: w = '{UOP_TICK,   COND_NONE,     UA_START,  1'b1};
         4'd11: w = '{UOP_NOP,    COND_NOT_DONE, UA_IGNORE, 1'b0};
         4'd12: w = '{UOP_CINIT,  COND_NONE,     UA_START,  1'b0};
         4'd13: w = '{UOP_CEMIT,  COND_MORE,     UA_CEMIT,  1'b1};
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] ucode_entry(input logic [REQ_W-1:0] req);
      logic [UPC_W-1:0] a;
      case (req)
         REQ_START:   a = UA_START;
         REQ_RD_DONE: a = UA_RD;
         REQ_RD_FAIL: a = UA_FAIL;
         REQ_TICK:    a = UA_TICK;
         REQ_COLLECT: a = UA_COL;
         default:     a = UA_IGNORE;
      endcase
      return a;
   endfunction

   function automatic logic uop_emits(input uop_type op);
      return (op == UOP_ISSUE) || (op == UOP_TICK) || (op == UOP_REFUSE) ||
             (op == UOP_IGNORE) || (op == UOP_CEMIT);
   endfunction

   function automatic logic [REG_W-1:0] seq_reg(input logic [STEP_W-1:0] s);
      logic [REG_W-1:0] r;
      case (s)
         STEP_ADC:  r = 6'h01;
         STEP_VBUS: r = 6'h05;
         STEP_CURR: r = 6'h07;
         default:   r = 6'h06;
      endcase
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] seq_len(input logic [STEP_W-1:0] s);
      logic [LEN_W-1:0] n;
      case (s)
         STEP_ADC:  n = 2'd2;
         STEP_VBUS: n = 2'd3;
         STEP_CURR: n = 2'd3;
         default:   n = 2'd2;
      endcase
      return n;
   endfunction

   function automatic logic [BUS_W-1:0] bus_code(input poll_state_type st);
      logic [BUS_W-1:0] c;
      unique case (st)
         POLL_IDLE: c = BUS_IDLE;
         POLL_BUSY: c = BUS_BUSY;
         POLL_DONE: c = BUS_DONE;
         default:   c = BUS_IDLE;
      endcase
      return c;
   endfunction

endpackage

// File: sv/multi_channel_monitor_poller.sv
// ----------------------------------------------------------------------------
// multi_channel_monitor_poller
// Event-driven poller for a row of power-monitor chips, microcoded control.
// ----------------------------------------------------------------------------
// Each event runs a micro-program that writes the result register; collect emits
// one result per channel, one per cycle while the result port does not stall.
// The next transaction is taken the cycle after the program ends.
// A stalled result port holds the sequencer on its next emitting step.
// Reset (synchronous): poller idle, all channel stores zero, timeout 10 ms.
module multi_channel_monitor_poller #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // event channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mcmp_pkg::REQ_W-1:0]           req_type,
   input  logic [mcmp_pkg::BYTE_W-1:0]          req_byte0,
   input  logic [mcmp_pkg::BYTE_W-1:0]          req_byte1,
   input  logic [mcmp_pkg::BYTE_W-1:0]          req_byte2,
   input  logic [mcmp_pkg::TIME_W-1:0]          req_now_ms,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcmp_pkg::KIND_W-1:0]          rsp_cmd_kind,
   output logic [mcmp_pkg::CH_W-1:0]            rsp_channel,
   output logic [mcmp_pkg::REG_W-1:0]           rsp_cmd_reg,
   output logic [mcmp_pkg::LEN_W-1:0]           rsp_cmd_len,
   output logic [mcmp_pkg::BUS_W-1:0]           rsp_bus_state,
   output logic [mcmp_pkg::STAT_W-1:0]          rsp_status,
   output logic [mcmp_pkg::VBUS_W-1:0]          rsp_out_vbus,
   output logic signed [mcmp_pkg::CURR_W-1:0]   rsp_out_current,
   output logic signed [mcmp_pkg::TEMP_W-1:0]   rsp_out_dietemp,
   output logic [mcmp_pkg::TIME_W-1:0]          rsp_out_timestamp,
   output logic                                 rsp_out_cfg_ok,
   output logic                                 rsp_out_last,
   // configuration
   input  logic                                 csr_we,
   input  logic [mcmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcmp_pkg::CSR_W-1:0]           csr_wdata
);
   import mcmp_pkg::*;

   // channel counter must reach NUM_CHANNELS (end of cycle marker)
   localparam int CW = $clog2(NUM_CHANNELS + 1);
   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CW-1:0] CH_END   = CW'(NUM_CHANNELS);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CHANNELS - 1);

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [CH_W-1:0]          channel;
      logic [REG_W-1:0]         cmd_reg;
      logic [LEN_W-1:0]         cmd_len;
      logic [BUS_W-1:0]         bus_state;
      logic [STAT_W-1:0]        status;
      logic [VBUS_W-1:0]        vbus;
      logic [CURR_W-1:0]        current;
      logic [TEMP_W-1:0]        dietemp;
      logic [TIME_W-1:0]        timestamp;
      logic                     cfg_ok;
      logic                     last;
   } rsp_type;

   // configuration registers
   logic [CSR_W-1:0]   expected_adc_ff;
   logic [CSR_W-1:0]   timeout_ff;

   // sequencer
   logic               run_ff, run_in;
   logic [UPC_W-1:0]   upc_ff, upc_in;
   ucw_type            ucw;
   logic               exec;
   logic               cond_hit;

   // latched event
   logic [BYTE_W-1:0]  b0_ff, b1_ff, b2_ff;
   logic [TIME_W-1:0]  now_ff;

   // poller datapath
   poll_state_type     poll_ff, poll_in;
   logic [CW-1:0]      chan_ff, chan_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [TIME_W-1:0]  op_start_ff, op_start_in;
   logic [IW-1:0]      col_idx_ff, col_idx_in;
   logic [IW-1:0]      wr_idx;
   logic [TIME_W-1:0]  elapsed;
   logic               timed_out;
   logic [23:0]        word24;
   logic [15:0]        word16;

   // per-channel stores, one read port (collect index)
   logic [VBUS_W-1:0]  vbus_ff      [NUM_CHANNELS];
   logic [CURR_W-1:0]  current_ff   [NUM_CHANNELS];
   logic [TEMP_W-1:0]  dietemp_ff   [NUM_CHANNELS];
   logic [TIME_W-1:0]  timestamp_ff [NUM_CHANNELS];
   logic               cfg_ok_ff    [NUM_CHANNELS];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               out_free;
   logic               emit;

   assign req_stall = run_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ucw       = ucode_rom(upc_ff);
   assign exec      = run_ff && (!uop_emits(ucw.uop) || out_free);
   assign emit      = exec && uop_emits(ucw.uop);
   assign wr_idx    = chan_ff[IW-1:0];
   assign elapsed   = now_ff - op_start_ff;
   assign timed_out = elapsed > {16'd0, timeout_ff};
   assign word24    = {b0_ff, b1_ff, b2_ff};
   assign word16    = {b0_ff, b1_ff};

   // conditional jump test, on register values before this step's update
   always_comb begin
      case (ucw.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_BUSY:     cond_hit = (poll_ff == POLL_BUSY);
         COND_NOT_BUSY: cond_hit = (poll_ff != POLL_BUSY);
         COND_NOT_DONE: cond_hit = (poll_ff != POLL_DONE);
         COND_MORE:     cond_hit = (col_idx_ff != LAST_IDX);
         default:       cond_hit = 1'b0;
      endcase
   end

   // sequencer: step counter, jumps and program end
   always_comb begin
      run_in = run_ff;
      upc_in = upc_ff;
      if (!run_ff) begin
         if (req_valid) begin
            run_in = 1'b1;
            upc_in = ucode_entry(req_type);
         end
      end else if (exec) begin
         if (cond_hit) begin
            upc_in = ucw.target;
         end else if (ucw.last) begin
            run_in = 1'b0;
         end else begin
            upc_in = upc_ff + UPC_W'(1);
         end
      end
   end

   // datapath driven by the control word
   always_comb begin
      poll_in     = poll_ff;
      chan_in     = chan_ff;
      step_in     = step_ff;
      op_start_in = op_start_ff;
      col_idx_in  = col_idx_ff;
      if (exec) begin
         case (ucw.uop)
            UOP_START: begin
               chan_in = '0;
               step_in = STEP_ADC;
               poll_in = POLL_BUSY;
            end
            UOP_STORE: begin
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_TEMP) begin
                  chan_in = chan_ff + CW'(1);
               end
            end
            UOP_SKIP: begin
               step_in = STEP_ADC;
               chan_in = chan_ff + CW'(1);
            end
            UOP_ISSUE: begin
               if (chan_ff >= CH_END) begin
                  poll_in = POLL_DONE;
               end else begin
                  op_start_in = now_ff;
               end
            end
            UOP_TICK: begin
               if (timed_out) begin
                  poll_in = POLL_IDLE;
               end
            end
            UOP_CINIT: begin
               poll_in    = POLL_IDLE;
               col_idx_in = '0;
            end
            UOP_CEMIT: begin
               col_idx_in = col_idx_ff + IW'(1);
            end
            default: ;
         endcase
      end
   end

   // result assembly; bus_state reports the state after the event
   always_comb begin
      rsp_in           = '0;
      rsp_in.bus_state = bus_code(poll_in);
      rsp_in.last      = 1'b1;
      case (ucw.uop)
         UOP_ISSUE: begin
            if (chan_ff < CH_END) begin
               rsp_in.kind    = CMD_READ;
               rsp_in.channel = CH_W'(chan_ff);
               rsp_in.cmd_reg = seq_reg(step_ff);
               rsp_in.cmd_len = seq_len(step_ff);
            end
         end
         UOP_TICK: begin
            if (timed_out) begin
               rsp_in.kind    = CMD_ABORT;
               rsp_in.channel = CH_W'(chan_ff);
            end
         end
         UOP_REFUSE: rsp_in.status = STAT_REFUSED;
         UOP_IGNORE: rsp_in.status = STAT_IGNORED;
         UOP_CEMIT: begin
            rsp_in.channel   = CH_W'(col_idx_ff);
            rsp_in.vbus      = vbus_ff[col_idx_ff];
            rsp_in.current   = current_ff[col_idx_ff];
            rsp_in.dietemp   = dietemp_ff[col_idx_ff];
            rsp_in.timestamp = timestamp_ff[col_idx_ff];
            rsp_in.cfg_ok    = cfg_ok_ff[col_idx_ff];
            rsp_in.last      = (col_idx_ff == LAST_IDX);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         upc_ff       <= '0;
         poll_ff      <= POLL_IDLE;
         chan_ff      <= '0;
         step_ff      <= '0;
         op_start_ff  <= '0;
         col_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         upc_ff       <= upc_in;
         poll_ff      <= poll_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         op_start_ff  <= op_start_in;
         col_idx_ff   <= col_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_adc_ff <= '0;
         timeout_ff      <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_ADC: expected_adc_ff <= csr_wdata;
            CSR_TIMEOUT:      timeout_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // event latch and result payload
   always_ff @(posedge clock) begin
      if (!run_ff && req_valid) begin
         b0_ff  <= req_byte0;
         b1_ff  <= req_byte1;
         b2_ff  <= req_byte2;
         now_ff <= req_now_ms;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // channel stores: parse received bytes by sequence step
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            vbus_ff[i]      <= '0;
            current_ff[i]   <= '0;
            dietemp_ff[i]   <= '0;
            timestamp_ff[i] <= '0;
            cfg_ok_ff[i]    <= 1'b0;
         end
      end else if (exec && ucw.uop == UOP_STORE) begin
         case (step_ff)
            STEP_ADC:  cfg_ok_ff[wr_idx]  <= (word16 == expected_adc_ff);
            STEP_VBUS: vbus_ff[wr_idx]    <= word24[23:4];
            STEP_CURR: current_ff[wr_idx] <= word24[23:4];
            default: begin
               dietemp_ff[wr_idx]   <= word16;
               timestamp_ff[wr_idx] <= now_ff;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cmd_kind      = rsp_ff.kind;
   assign rsp_channel       = rsp_ff.channel;
   assign rsp_cmd_reg       = rsp_ff.cmd_reg;
   assign rsp_cmd_len       = rsp_ff.cmd_len;
   assign rsp_bus_state     = rsp_ff.bus_state;
   assign rsp_status        = rsp_ff.status;
   assign rsp_out_vbus      = rsp_ff.vbus;
   assign rsp_out_current   = rsp_ff.current;
   assign rsp_out_dietemp   = rsp_ff.dietemp;
   assign rsp_out_timestamp = rsp_ff.timestamp;
   assign rsp_out_cfg_ok    = rsp_ff.cfg_ok;
   assign rsp_out_last      = rsp_ff.last;

endmodule
